// ----- design/mst_pkg.sv -----
// Package for the multi-slot countdown timer.
// Holds slot count, command/status/phase/state codes and the structs passed between the modules.
// No dependencies.
package mst_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_ADD_ONCE = 3'd1,
        CMD_ADD_REP  = 3'd2,
        CMD_CANCEL   = 3'd3,
        CMD_REAP     = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_BUSY      = 3'd4,
        ST_RUNNING   = 3'd5,
        ST_EXPIRED   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_NONE      = 2'd0,
        PH_RUNNING   = 2'd1,
        PH_CANCELLED = 2'd2,
        PH_FINISHED  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FINAL,
        S_ADD,
        S_CHECK,
        S_REPLY
    } t_state;

    // write request to the slot store, all at the current slot index
    typedef struct packed {
        logic        we_new;
        logic [15:0] new_period;
        logic [15:0] new_tag;
        logic        new_repeat;
        logic        we_rem;
        logic [15:0] rem;
        logic        we_phase;
        t_phase      phase;
        logic        clear;
    } t_st_wr;

    typedef struct packed {
        logic        used;
        t_phase      phase;
        logic        repeat_en;
        logic [15:0] period;
        logic [15:0] rem;
        logic [15:0] tag;
    } t_st_rd;

    typedef struct packed {
        logic [15:0] next_rem;
        logic        expire;
    } t_dec_res;

endpackage

// ----- design/multi_slot_countdown_timer.sv -----
// Top level of the multi-slot countdown timer: command sequencer and output register.
// Depends on mst_pkg, mst_dec_unit and mst_slot_store.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   input   | i_in_valid / o_in_stall | i_command, i_period, i_tag, i_slot
//   output  | o_out_valid / i_out_stall | o_status, o_result_slot, o_result_tag, o_last
//
// One command at a time; o_in_stall is high from acceptance until its last result is loaded.
// Tick: the walk steps through every slot via the shared countdown unit, then the final
// state loads the closing result. Add: slots are scanned up to and including the first
// free one (at most NUM_SLOTS), then the reply state loads the result. Cancel and reap
// pass through a check state before the reply state; rejected commands go straight to
// the reply state.
// A stalled output register holds the walk at the slot that wants to report.
// Synchronous active-low reset frees all slots; no clearing pass is needed.
module multi_slot_countdown_timer import mst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_period,
    input  logic [15:0] i_tag,
    input  logic [3:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_result_slot,
    output logic [15:0] o_result_tag,
    output logic        o_last
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_period, r_tag;
    logic             r_repeat;
    t_status          r_status, n_status;
    logic [3:0]       r_rslot, n_rslot;

    logic             r_ov;
    t_status          r_ost;
    logic [3:0]       r_oslot;
    logic [15:0]      r_otag;
    logic             r_olast;

    logic             accept;
    logic             out_free;
    logic             emit;
    t_status          e_status;
    logic [3:0]       e_slot;
    logic [15:0]      e_tag;
    logic             e_last;
    logic             active;
    logic             slot_oob;

    t_st_wr           wr;
    t_st_rd           rd;
    t_dec_res         dres;

    mst_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_wr    (wr),
        .o_rd    (rd)
    );

    mst_dec_unit u_dec (
        .i_rem    (rd.rem),
        .i_period (rd.period),
        .i_repeat (rd.repeat_en),
        .o_res    (dres)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;
    assign active     = rd.used && (rd.phase == PH_RUNNING);
    assign slot_oob   = ({3'b000, i_slot} >= 7'(NUM_SLOTS));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_status   = r_status;
        n_rslot    = r_rslot;
        emit       = 1'b0;
        e_status   = r_status;
        e_slot     = r_rslot;
        e_tag      = 16'd0;
        e_last     = 1'b1;
        wr         = '0;
        wr.phase   = PH_NONE;
        wr.new_period = r_period;
        wr.new_tag    = r_tag;
        wr.new_repeat = r_repeat;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx    = '0;
                    n_rslot  = 4'd0;
                    n_status = ST_INVALID;
                    priority case (i_command)
                        CMD_TICK: begin
                            n_state = S_TICK;
                        end
                        CMD_ADD_ONCE, CMD_ADD_REP: begin
                            n_state = (i_period == 16'd0) ? S_REPLY : S_ADD;
                        end
                        CMD_CANCEL, CMD_REAP: begin
                            n_rslot = i_slot;
                            n_idx   = IDX_W'(i_slot);
                            n_state = slot_oob ? S_REPLY : S_CHECK;
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end

            S_TICK: begin
                // hold the walk while an expiry cannot be loaded
                if (!(active && dres.expire) || out_free) begin
                    if (active) begin
                        wr.we_rem = 1'b1;
                        wr.rem    = dres.next_rem;
                        if (dres.expire) begin
                            emit     = 1'b1;
                            e_status = ST_EXPIRED;
                            e_slot   = 4'(r_idx);
                            e_tag    = rd.tag;
                            e_last   = 1'b0;
                            if (!rd.repeat_en) begin
                                wr.we_phase = 1'b1;
                                wr.phase    = PH_FINISHED;
                            end
                        end
                    end
                    if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                        n_state = S_FINAL;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            S_FINAL: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = ST_OK;
                    e_slot   = 4'd0;
                    n_state  = S_IDLE;
                end
            end

            S_ADD: begin
                if (!rd.used) begin
                    wr.we_new = 1'b1;
                    n_status  = ST_OK;
                    n_rslot   = 4'(r_idx);
                    n_state   = S_REPLY;
                end else if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                    n_status  = ST_NOSPACE;
                    n_state   = S_REPLY;
                end else begin
                    n_idx     = r_idx + IDX_W'(1);
                end
            end

            S_CHECK: begin
                n_state = S_REPLY;
                if (!rd.used) begin
                    n_status = ST_INVALID;
                end else if (!r_repeat) begin
                    // r_repeat is clear for cancel: cancel rules
                    if (rd.phase == PH_CANCELLED) begin
                        n_status = ST_CANCELLED;
                    end else if (rd.phase == PH_FINISHED) begin
                        n_status = ST_BUSY;
                    end else begin
                        wr.we_phase = 1'b1;
                        wr.phase    = PH_CANCELLED;
                        n_status    = ST_OK;
                    end
                end else begin
                    if (rd.repeat_en) begin
                        n_status = ST_BUSY;
                    end else if (rd.phase == PH_RUNNING) begin
                        n_status = ST_RUNNING;
                    end else begin
                        wr.clear = 1'b1;
                        n_status = ST_OK;
                    end
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rslot  <= n_rslot;
        if (accept) begin
            r_period <= i_period;
            r_tag    <= i_tag;
            // repeat flag doubles as the reap marker for slot commands
            r_repeat <= (i_command == CMD_ADD_REP) || (i_command == CMD_REAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ost   <= e_status;
            r_oslot <= e_slot;
            r_otag  <= e_tag;
            r_olast <= e_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_ost;
    assign o_result_slot = r_oslot;
    assign o_result_tag  = r_otag;
    assign o_last        = r_olast;

endmodule

// ----- design/mst_dec_unit.sv -----
// Shared countdown unit: decrement, zero compare and reload select for one slot.
// Depends on mst_pkg.
module mst_dec_unit import mst_pkg::*; (
    input  logic [15:0] i_rem,
    input  logic [15:0] i_period,
    input  logic        i_repeat,
    output t_dec_res    o_res
);

    logic [15:0] dec;

    assign dec = i_rem - 16'd1;

    always_comb begin
        if (i_rem == 16'd0) begin
            // wrap without expiry
            o_res.next_rem = 16'hFFFF;
            o_res.expire   = 1'b0;
        end else begin
            o_res.expire   = (dec == 16'd0);
            o_res.next_rem = (o_res.expire && i_repeat) ? i_period : dec;
        end
    end

endmodule

// ----- design/mst_slot_store.sv -----
// Slot table: per-slot flags with reset, plus period, remaining and tag storage.
// A single index serves both the read and the write. Depends on mst_pkg.
module mst_slot_store import mst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_st_wr           i_wr,
    output t_st_rd           o_rd
);

    logic [NUM_SLOTS-1:0] r_used;
    logic [NUM_SLOTS-1:0] r_repeat;
    t_phase               r_phase  [NUM_SLOTS];
    logic [15:0]          r_period [NUM_SLOTS];
    logic [15:0]          r_rem    [NUM_SLOTS];
    logic [15:0]          r_tag    [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_repeat <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_phase[i] <= PH_NONE;
            end
        end else begin
            if (i_wr.we_new) begin
                r_used[i_idx]   <= 1'b1;
                r_repeat[i_idx] <= i_wr.new_repeat;
                r_phase[i_idx]  <= PH_RUNNING;
            end else if (i_wr.clear) begin
                r_used[i_idx]   <= 1'b0;
                r_repeat[i_idx] <= 1'b0;
                r_phase[i_idx]  <= PH_NONE;
            end else if (i_wr.we_phase) begin
                r_phase[i_idx]  <= i_wr.phase;
            end
        end
    end

    // payload storage is only read for used slots, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.we_new) begin
            r_period[i_idx] <= i_wr.new_period;
            r_rem[i_idx]    <= i_wr.new_period;
            r_tag[i_idx]    <= i_wr.new_tag;
        end else if (i_wr.we_rem) begin
            r_rem[i_idx]    <= i_wr.rem;
        end
    end

    always_comb begin
        o_rd.used      = r_used[i_idx];
        o_rd.repeat_en = r_repeat[i_idx];
        o_rd.phase     = r_phase[i_idx];
        o_rd.period    = r_period[i_idx];
        o_rd.rem       = r_rem[i_idx];
        o_rd.tag       = r_tag[i_idx];
    end

endmodule
